### design/ktd_pkg.sv
// ----------------------------------------------------------------------------
// ktd_pkg
// Types and constants shared by the keyed table difference block: request
// opcodes, result categories, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package ktd_pkg;

    localparam int ID_W   = 32;
    localparam int HASH_W = 32;
    localparam int ENT_W  = ID_W + HASH_W;

    typedef enum logic [1:0] {
        OP_LOAD_BASE = 2'd0,
        OP_LOAD_MOD  = 2'd1,
        OP_COMPARE   = 2'd2,
        OP_NONE      = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        CAT_ADDED   = 2'd0,
        CAT_REMOVED = 2'd1,
        CAT_CHANGED = 2'd2,
        CAT_NONE    = 2'd3
    } t_cat;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OUTER_RD,
        ST_OUTER_LAT,
        ST_INNER_RD,
        ST_INNER_CHK,
        ST_DECIDE,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic in_ready;
        t_cat cat;
        logic i_clear;
        logic i_step;
        logic load_outer;
        logic inner_step;
        logic capture_match;
        logic load_pend;
        logic push;
        logic push_last;
        logic push_none;
        logic clear_tables;
    } t_cmd;

    typedef struct packed {
        logic cmp_req;
        logic outer_done;
        logic inner_empty;
        logic inner_match;
        logic inner_last;
        logic found;
        logic hash_diff;
        logic pend_valid;
        logic out_free;
    } t_sts;

endpackage

### design/ktd_if.sv
// ----------------------------------------------------------------------------
// ktd_if
// Valid/ready channels of the keyed table difference block: the request
// channel carrying loads and compares, and the result channel.
// ----------------------------------------------------------------------------
interface ktd_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         op;
    logic signed [31:0] set_id;
    logic [31:0]        content_hash;

    modport source (output valid, output op, output set_id, output content_hash,
                    input ready);
    modport sink   (input valid, input op, input set_id, input content_hash,
                    output ready);
endinterface

interface ktd_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         category;
    logic signed [31:0] diff_id;
    logic               last;

    modport source (output valid, output category, output diff_id, output last,
                    input ready);
    modport sink   (input valid, input category, input diff_id, input last,
                    output ready);
endinterface

### design/keyed_table_difference.sv
// ----------------------------------------------------------------------------
// keyed_table_difference
// Loads a base and a modified table of (id, hash) entries and reports the
// added, removed and changed ids on a compare request.
// ----------------------------------------------------------------------------
// Usage:
//   i_req carries requests: op 0 loads a base entry, op 1 a modified entry,
//   op 2 starts a compare, op 3 is dropped. Loads beyond TABLE_CAPACITY are
//   dropped. o_rsp carries results (category, diff_id, last).
//   Loads and dropped requests are accepted back to back.
//   A compare holds i_req ready low while it runs: three passes (added,
//   removed, changed), each walking the outer table and searching the inner
//   table through the single read port of each table RAM. Each inner entry
//   probed passes through INNER_RD and INNER_CHK, each outer entry through
//   OUTER_RD, OUTER_LAT and DECIDE. Full tables give the longest compare.
//   Results leave through an output register; one result is held back so
//   the final one can carry last. A compare with no difference gives one
//   no-difference result. Both tables empty after every compare.
//   While o_rsp is stalled the compare pauses at its next result; a finished
//   result waits in the output register while new loads are taken.
//   Reset empties both tables and drops any result in flight.
// ----------------------------------------------------------------------------
module keyed_table_difference
    import ktd_pkg::*;
#(
    parameter int TABLE_CAPACITY = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ktd_in_if.sink    i_req,
    ktd_out_if.source o_rsp
);

    t_cmd cmd;
    t_sts sts;

    ktd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    ktd_dpath #(
        .TABLE_CAPACITY (TABLE_CAPACITY)
    ) u_dpath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (cmd),
        .o_sts   (sts)
    );

endmodule

### design/ktd_ram.sv
// ----------------------------------------------------------------------------
// ktd_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module ktd_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/ktd_dpath.sv
// ----------------------------------------------------------------------------
// ktd_dpath
// Datapath: base and modified table RAMs, fill counts, scan indexes, key
// compare, pending result and result output register.
// ----------------------------------------------------------------------------
module ktd_dpath
    import ktd_pkg::*;
#(
    parameter int TABLE_CAPACITY = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ktd_in_if.sink         i_req,
    ktd_out_if.source      o_rsp,
    input  t_cmd           i_cmd,
    output t_sts           o_sts
);

    localparam int CW = $clog2(TABLE_CAPACITY + 1);
    localparam int AW = (TABLE_CAPACITY > 1) ? $clog2(TABLE_CAPACITY) : 1;

    logic [CW-1:0]     r_base_cnt;
    logic [CW-1:0]     r_mod_cnt;
    logic [CW-1:0]     r_i;
    logic [CW-1:0]     r_j;
    logic [ID_W-1:0]   r_key;
    logic [HASH_W-1:0] r_hash;
    logic              r_found;
    logic [HASH_W-1:0] r_found_hash;
    logic              r_pend_valid;
    t_cat              r_pend_cat;
    logic [ID_W-1:0]   r_pend_id;
    logic              r_out_valid;
    t_cat              r_out_cat;
    logic [ID_W-1:0]   r_out_id;
    logic              r_out_last;

    logic              accept;
    logic              wr_base;
    logic              wr_mod;
    logic              outer_is_base;
    logic [AW-1:0]     base_raddr;
    logic [AW-1:0]     mod_raddr;
    logic [ENT_W-1:0]  base_rdata;
    logic [ENT_W-1:0]  mod_rdata;
    logic [ENT_W-1:0]  wdata;
    logic [ENT_W-1:0]  outer_data;
    logic [ENT_W-1:0]  inner_data;
    logic [CW-1:0]     outer_cnt;
    logic [CW-1:0]     inner_cnt;
    logic              out_free;

    assign i_req.ready   = i_cmd.in_ready;
    assign accept        = i_req.valid && i_cmd.in_ready;
    assign wr_base       = accept && (i_req.op == OP_LOAD_BASE)
                           && (r_base_cnt < CW'(TABLE_CAPACITY));
    assign wr_mod        = accept && (i_req.op == OP_LOAD_MOD)
                           && (r_mod_cnt < CW'(TABLE_CAPACITY));
    assign wdata         = {i_req.set_id, i_req.content_hash};

    assign outer_is_base = (i_cmd.cat == CAT_REMOVED);
    assign base_raddr    = outer_is_base ? r_i[AW-1:0] : r_j[AW-1:0];
    assign mod_raddr     = outer_is_base ? r_j[AW-1:0] : r_i[AW-1:0];
    assign outer_data    = outer_is_base ? base_rdata : mod_rdata;
    assign inner_data    = outer_is_base ? mod_rdata : base_rdata;
    assign outer_cnt     = outer_is_base ? r_base_cnt : r_mod_cnt;
    assign inner_cnt     = outer_is_base ? r_mod_cnt : r_base_cnt;
    assign out_free      = !r_out_valid || o_rsp.ready;

    ktd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_CAPACITY),
        .AW    (AW)
    ) u_base_ram (
        .i_clk   (i_clk),
        .i_we    (wr_base),
        .i_waddr (r_base_cnt[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (base_raddr),
        .o_rdata (base_rdata)
    );

    ktd_ram #(
        .WIDTH (ENT_W),
        .DEPTH (TABLE_CAPACITY),
        .AW    (AW)
    ) u_mod_ram (
        .i_clk   (i_clk),
        .i_we    (wr_mod),
        .i_waddr (r_mod_cnt[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (mod_raddr),
        .o_rdata (mod_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_cnt <= '0;
            r_mod_cnt  <= '0;
        end else if (i_cmd.clear_tables) begin
            r_base_cnt <= '0;
            r_mod_cnt  <= '0;
        end else begin
            if (wr_base) begin
                r_base_cnt <= r_base_cnt + CW'(1);
            end
            if (wr_mod) begin
                r_mod_cnt <= r_mod_cnt + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_j <= '0;
        end else begin
            if (i_cmd.i_clear) begin
                r_i <= '0;
            end else if (i_cmd.i_step) begin
                r_i <= r_i + CW'(1);
            end
            if (i_cmd.load_outer) begin
                r_j <= '0;
            end else if (i_cmd.inner_step) begin
                r_j <= r_j + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_outer) begin
            r_key  <= outer_data[ENT_W-1:HASH_W];
            r_hash <= outer_data[HASH_W-1:0];
        end
        if (i_cmd.capture_match) begin
            r_found_hash <= inner_data[HASH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load_outer) begin
            r_found <= 1'b0;
        end else if (i_cmd.capture_match) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.clear_tables) begin
            r_pend_valid <= 1'b0;
        end else if (i_cmd.load_pend) begin
            r_pend_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_pend) begin
            r_pend_cat <= i_cmd.cat;
            r_pend_id  <= r_key;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.push) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_out_cat  <= i_cmd.push_none ? CAT_NONE : r_pend_cat;
            r_out_id   <= i_cmd.push_none ? '0 : r_pend_id;
            r_out_last <= i_cmd.push_last;
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.category = r_out_cat;
    assign o_rsp.diff_id  = $signed(r_out_id);
    assign o_rsp.last     = r_out_last;

    always_comb begin
        o_sts.cmp_req     = i_req.valid && (i_req.op == OP_COMPARE);
        o_sts.outer_done  = (r_i == outer_cnt);
        o_sts.inner_empty = (inner_cnt == '0);
        o_sts.inner_match = (inner_data[ENT_W-1:HASH_W] == r_key);
        o_sts.inner_last  = ((r_j + CW'(1)) == inner_cnt);
        o_sts.found       = r_found;
        o_sts.hash_diff   = (r_found_hash != r_hash);
        o_sts.pend_valid  = r_pend_valid;
        o_sts.out_free    = out_free;
    end

`ifndef ASSERT_OFF
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_base_cnt <= CW'(TABLE_CAPACITY)) && (r_mod_cnt <= CW'(TABLE_CAPACITY)))
        else $error("table count above capacity");

    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |-> out_free)
        else $error("result pushed over an unaccepted result");

    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.clear_tables |=> (r_base_cnt == '0) && (r_mod_cnt == '0) && !r_pend_valid)
        else $error("tables not emptied after compare");

    a_inner_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.inner_step |-> ((r_j + CW'(1)) < inner_cnt))
        else $error("inner scan past table fill");
`endif

endmodule

### design/ktd_ctrl.sv
// ----------------------------------------------------------------------------
// ktd_ctrl
// Controller: accepts requests while idle and sequences the three compare
// passes (added, removed, changed), each an outer walk with an inner search.
// ----------------------------------------------------------------------------
module ktd_ctrl
    import ktd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    t_state r_state;
    t_state n_state;
    t_cat   r_phase;
    t_cat   n_phase;
    logic   emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_phase <= CAT_ADDED;
        end else begin
            r_state <= n_state;
            r_phase <= n_phase;
        end
    end

    assign emit = (r_phase == CAT_CHANGED) ? (i_sts.found && i_sts.hash_diff)
                                           : !i_sts.found;

    always_comb begin
        n_state = r_state;
        n_phase = r_phase;
        o_cmd   = '0;
        o_cmd.cat = r_phase;
        case (r_state)
            ST_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_sts.cmp_req) begin
                    n_phase       = CAT_ADDED;
                    o_cmd.i_clear = 1'b1;
                    n_state       = ST_OUTER_RD;
                end
            end
            ST_OUTER_RD: begin
                if (i_sts.outer_done) begin
                    o_cmd.i_clear = 1'b1;
                    case (r_phase)
                        CAT_ADDED:   n_phase = CAT_REMOVED;
                        CAT_REMOVED: n_phase = CAT_CHANGED;
                        default:     n_state = ST_FINAL;
                    endcase
                end else begin
                    n_state = ST_OUTER_LAT;
                end
            end
            ST_OUTER_LAT: begin
                o_cmd.load_outer = 1'b1;
                n_state = i_sts.inner_empty ? ST_DECIDE : ST_INNER_RD;
            end
            ST_INNER_RD: begin
                n_state = ST_INNER_CHK;
            end
            ST_INNER_CHK: begin
                if (i_sts.inner_match) begin
                    o_cmd.capture_match = 1'b1;
                    n_state = ST_DECIDE;
                end else if (i_sts.inner_last) begin
                    n_state = ST_DECIDE;
                end else begin
                    o_cmd.inner_step = 1'b1;
                    n_state = ST_INNER_RD;
                end
            end
            ST_DECIDE: begin
                if (!(emit && i_sts.pend_valid && !i_sts.out_free)) begin
                    o_cmd.load_pend = emit;
                    o_cmd.push      = emit && i_sts.pend_valid;
                    o_cmd.i_step    = 1'b1;
                    n_state         = ST_OUTER_RD;
                end
            end
            ST_FINAL: begin
                if (i_sts.out_free) begin
                    o_cmd.push         = 1'b1;
                    o_cmd.push_last    = 1'b1;
                    o_cmd.push_none    = !i_sts.pend_valid;
                    o_cmd.clear_tables = 1'b1;
                    n_state            = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_push_last_final: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push_last |=> (r_state == ST_IDLE))
        else $error("final result pushed outside the end of a compare");

    a_idle_only_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.in_ready && i_sts.cmp_req) |=> (r_state == ST_OUTER_RD)
                                              && (r_phase == CAT_ADDED))
        else $error("compare request not started");
`endif

endmodule

### bench/keyed_table_difference_tb.sv
// ----------------------------------------------------------------------------
// keyed_table_difference_tb
// Drives load, compare and dropped requests into the keyed table difference
// block and checks every result against a predictor that keeps its own copy
// of both tables. Directed cases come first: empty and identical tables,
// extreme ids and hashes, repeated keys, dropped opcodes and full tables.
// Random table pairs follow, built from a shared base so that most keys
// match, with some entries dropped, rehashed or added. Both channels idle
// in random bursts until the last stretch, which runs without gaps.
// ----------------------------------------------------------------------------
module keyed_table_difference_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import ktd_pkg::*;

    localparam int CAP          = 32;
    localparam int HALF_PERIOD  = 6;
    localparam int RESET_CYCLES = 11;
    localparam int QUIET_LIMIT  = 30000;
    localparam int TAIL_CYCLES  = 100;
    localparam int BASE_TBL     = 0;
    localparam int MOD_TBL      = 1;

    typedef struct packed {
        logic signed [31:0] id;
        logic [31:0]        hash;
    } t_row;

    typedef struct packed {
        t_cat               cat;
        logic signed [31:0] id;
        logic               last;
    } t_diff;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ktd_in_if  req_if ();
    ktd_out_if rsp_if ();

    keyed_table_difference #(
        .TABLE_CAPACITY(CAP)
    ) u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_rsp  (rsp_if)
    );

    t_row  tables [2][CAP];
    int    fill [2]        = '{0, 0};
    t_diff pending_diffs[$];
    t_diff want;

    int errors          = 0;
    int requests_sent   = 0;
    int compares_done   = 0;
    int results_checked = 0;
    int widest_compare  = 0;
    int quiet_cycles    = 0;
    bit calm            = 1'b0;
    int gap_pct         = 20;
    int stall_pct       = 15;

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    function automatic int find_row(int tbl, logic [31:0] key);
        for (int i = 0; i < fill[tbl]; i++) begin
            if (tables[tbl][i].id == key) return i;
        end
        return -1;
    endfunction

    function automatic void record_load(int tbl, t_row row);
        if (fill[tbl] < CAP) begin
            tables[tbl][fill[tbl]] = row;
            fill[tbl]++;
        end
    endfunction

    function automatic void list_differences();
        t_diff found[$];
        int    hit;
        for (int i = 0; i < fill[MOD_TBL]; i++) begin
            if (find_row(BASE_TBL, tables[MOD_TBL][i].id) < 0)
                found.push_back('{CAT_ADDED, tables[MOD_TBL][i].id, 1'b0});
        end
        for (int i = 0; i < fill[BASE_TBL]; i++) begin
            if (find_row(MOD_TBL, tables[BASE_TBL][i].id) < 0)
                found.push_back('{CAT_REMOVED, tables[BASE_TBL][i].id, 1'b0});
        end
        for (int i = 0; i < fill[MOD_TBL]; i++) begin
            hit = find_row(BASE_TBL, tables[MOD_TBL][i].id);
            if (hit >= 0 && tables[BASE_TBL][hit].hash != tables[MOD_TBL][i].hash)
                found.push_back('{CAT_CHANGED, tables[MOD_TBL][i].id, 1'b0});
        end
        if (found.size() == 0) found.push_back('{CAT_NONE, 32'sd0, 1'b0});
        found[found.size() - 1].last = 1'b1;
        if (found.size() > widest_compare) widest_compare = found.size();
        foreach (found[k]) pending_diffs.push_back(found[k]);
        fill[BASE_TBL] = 0;
        fill[MOD_TBL]  = 0;
        compares_done++;
    endfunction

    task automatic send_request(t_op op, logic signed [31:0] id, logic [31:0] hash);
        if (!calm && $urandom_range(1, 100) <= gap_pct) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.op           <= op;
        req_if.set_id       <= id;
        req_if.content_hash <= hash;
        do @(posedge i_clk); while (!req_if.ready);
        requests_sent++;
        case (op)
            OP_LOAD_BASE: begin
                record_load(BASE_TBL, '{id, hash});
            end
            OP_LOAD_MOD: begin
                record_load(MOD_TBL, '{id, hash});
            end
            OP_COMPARE: begin
                list_differences();
            end
            default: begin
            end
        endcase
    endtask

    task automatic send_table_pair(int n_base, int n_new, bit wide);
        t_row base_q[$];
        t_row mod_q[$];
        t_row row;
        t_row tmp;
        int   j;
        int   roll;
        for (int i = 0; i < n_base; i++) begin
            row.id   = wide ? $urandom : ($urandom_range(0, 23) - 12);
            row.hash = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 3);
            base_q.push_back(row);
        end
        foreach (base_q[i]) begin
            row  = base_q[i];
            roll = $urandom_range(0, 99);
            if (roll >= 15) begin
                if (roll < 35) row.hash = row.hash ^ ($urandom | 1);
                mod_q.push_back(row);
            end
        end
        for (int i = 0; i < n_new; i++) begin
            row.id   = wide ? $urandom : ($urandom_range(0, 23) - 12);
            row.hash = $urandom;
            mod_q.push_back(row);
        end
        for (int i = mod_q.size() - 1; i > 0; i--) begin
            j        = $urandom_range(0, i);
            tmp      = mod_q[i];
            mod_q[i] = mod_q[j];
            mod_q[j] = tmp;
        end
        while (base_q.size() != 0 || mod_q.size() != 0) begin
            if (!calm && $urandom_range(0, 19) == 0)
                send_request(OP_NONE, $urandom, $urandom);
            if (mod_q.size() == 0 || (base_q.size() != 0 && $urandom_range(0, 1) == 1)) begin
                row = base_q.pop_front();
                send_request(OP_LOAD_BASE, row.id, row.hash);
            end else begin
                row = mod_q.pop_front();
                send_request(OP_LOAD_MOD, row.id, row.hash);
            end
        end
        send_request(OP_COMPARE, $urandom, $urandom);
    endtask

    task automatic run_table_pairs(int budget);
        int stop_at;
        int n;
        stop_at = requests_sent + budget;
        while (requests_sent < stop_at) begin
            gap_pct   = $urandom_range(0, 40);
            stall_pct = $urandom_range(0, 25);
            n = ($urandom_range(0, 15) == 0) ? $urandom_range(28, 36) : $urandom_range(0, 8);
            send_table_pair(n, $urandom_range(0, 3), $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic test_empty_tables();
        send_request(OP_COMPARE, 32'sd0, 32'h0);
        send_request(OP_LOAD_BASE, 32'sd4, 32'h4);
        send_request(OP_LOAD_MOD, 32'sd4, 32'h4);
        send_request(OP_COMPARE, 32'sd0, 32'h0);
    endtask

    task automatic test_extreme_fields();
        send_request(OP_LOAD_BASE, 32'h8000_0000, 32'h0000_0000);
        send_request(OP_LOAD_BASE, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_LOAD_BASE, 32'h0000_0000, 32'h5A5A_5A5A);
        send_request(OP_LOAD_MOD, 32'hFFFF_FFFF, 32'h0000_0001);
        send_request(OP_LOAD_MOD, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_LOAD_MOD, 32'h8000_0000, 32'hA5A5_A5A5);
        send_request(OP_COMPARE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_repeated_keys();
        send_request(OP_LOAD_BASE, 32'sd5, 32'hA);
        send_request(OP_LOAD_BASE, 32'sd5, 32'hB);
        send_request(OP_LOAD_MOD, 32'sd5, 32'hB);
        send_request(OP_LOAD_MOD, 32'sd11, 32'hD);
        send_request(OP_LOAD_MOD, 32'sd11, 32'hD);
        send_request(OP_COMPARE, 32'sd0, 32'h0);
    endtask

    task automatic test_dropped_opcode();
        send_request(OP_LOAD_BASE, 32'sd3, 32'h1);
        send_request(OP_NONE, 32'sd3, 32'h2);
        send_request(OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(OP_COMPARE, 32'sd0, 32'h0);
    endtask

    task automatic test_full_tables();
        for (int i = 0; i < CAP + 2; i++) send_request(OP_LOAD_BASE, 1000 + i, $urandom);
        for (int i = 0; i < CAP + 2; i++) send_request(OP_LOAD_MOD, -1000 - i, $urandom);
        send_request(OP_COMPARE, $urandom, $urandom);
    endtask

    task automatic test_random_pairs();
        run_table_pairs(260);
    endtask

    task automatic test_steady_flow();
        calm = 1'b1;
        run_table_pairs(60);
    endtask

    initial begin
        rsp_if.ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(1, 100) <= stall_pct) begin
                rsp_if.ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            results_checked++;
            if (pending_diffs.size() == 0) begin
                $error("result with nothing pending: category %0d, diff_id %0d, last %0d",
                       rsp_if.category, rsp_if.diff_id, rsp_if.last);
                errors++;
            end else begin
                want = pending_diffs.pop_front();
                if (rsp_if.category !== want.cat) begin
                    $error("category: expected %0d, actual %0d", want.cat, rsp_if.category);
                    errors++;
                end
                if (rsp_if.diff_id !== want.id) begin
                    $error("diff_id: expected %0d, actual %0d", want.id, rsp_if.diff_id);
                    errors++;
                end
                if (rsp_if.last !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, rsp_if.last);
                    errors++;
                end
            end
        end
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("timeout: no request or result moved for %0d cycles", QUIET_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        i_rst_n             <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.op           <= OP_NONE;
        req_if.set_id       <= '0;
        req_if.content_hash <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_tables();
        test_extreme_fields();
        test_repeated_keys();
        test_dropped_opcode();
        test_full_tables();
        test_random_pairs();
        test_steady_flow();

        req_if.valid <= 1'b0;
        while (pending_diffs.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("%0d requests sent, %0d compares, %0d results checked", requests_sent,
                 compares_done, results_checked);
        $display("largest single compare gave %0d results, %0d mismatches", widest_compare,
                 errors);
        if (errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
